// File: rtl/grid_point_snap_macros.svh
// Assertion macros for the grid point snap checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef GRID_POINT_SNAP_MACROS_SVH
`define GRID_POINT_SNAP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid_point_snap assertion failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define GPS_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("grid_point_snap assertion failed");

`endif

// File: rtl/gps_pkg.sv
// Shared constants, register codes and stage types for the grid point snap block.
// No dependencies; every module of the block imports this package.
package gps_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SIZE_W     = 31;
  localparam int INV_W      = 33;
  localparam int INV_FRAC   = 32;
  localparam int SCALE      = FRAC_BITS + INV_FRAC;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = DIFF_W + INV_W + 1;
  localparam int IDX_W      = PROD_W + 1 - SCALE;
  localparam int K_W        = IDX_W + 3;
  localparam int V_W        = K_W + SIZE_W + 1;
  localparam int SUM_W      = V_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = INV_W;
  localparam int PIPE_DEPTH = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SIZE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PITCH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd7;

  localparam logic [1:0] SHAPE_SQUARE = 2'd0;
  localparam logic [1:0] SHAPE_ROWS   = 2'd1;
  localparam logic [1:0] SHAPE_COLS   = 2'd2;
  localparam logic [1:0] SHAPE_UNUSED = 2'd3;

  typedef struct packed {
    logic                      enabled;
    logic [1:0]                shape;
    logic [SIZE_W-1:0]         cell_size;
    logic [SIZE_W-1:0]         row_pitch;
    logic [INV_W-1:0]          inv_cell_size;
    logic [INV_W-1:0]          inv_row_pitch;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
  } gps_cfg_t;

  // Scaled offsets leaving the multiply section.
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [PROD_W-1:0]  qx;
    logic signed [PROD_W-1:0]  qy;
  } gps_prod_t;

  // Lattice multipliers leaving the index section.
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [K_W-1:0]     kx;
    logic signed [K_W-1:0]     ky;
  } gps_idx_t;

endpackage

// File: rtl/gps_cfg_regs.sv
// Configuration register file of the grid point snap block.
// Depends on gps_pkg for register codes and the configuration struct.
module gps_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output gps_pkg::gps_cfg_t                cfg
);
  import gps_pkg::*;

  gps_cfg_t regs;

  assign cfg_ready = ~rst;
  assign cfg      = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enabled       <= 1'b0;
      regs.shape         <= SHAPE_SQUARE;
      regs.cell_size     <= 31'd65536;
      regs.row_pitch     <= 31'd56756;
      regs.inv_cell_size <= 33'd4294967296;
      regs.inv_row_pitch <= 33'd4959401045;
      regs.origin_x      <= '0;
      regs.origin_y      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLED:   regs.enabled       <= cfg_data[0];
        CFG_SHAPE:     regs.shape         <= cfg_data[1:0];
        CFG_CELL_SIZE: regs.cell_size     <= cfg_data[SIZE_W-1:0];
        CFG_ROW_PITCH: regs.row_pitch     <= cfg_data[SIZE_W-1:0];
        CFG_INV_SIZE:  regs.inv_cell_size <= cfg_data[INV_W-1:0];
        CFG_INV_PITCH: regs.inv_row_pitch <= cfg_data[INV_W-1:0];
        CFG_ORIGIN_X:  regs.origin_x      <= $signed(cfg_data[COORD_W-1:0]);
        CFG_ORIGIN_Y:  regs.origin_y      <= $signed(cfg_data[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/gps_front.sv
// Front section: offset from the origin, then scaling by the reciprocal spacing.
// Depends on gps_pkg; two register stages.
module gps_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic signed [gps_pkg::COORD_W-1:0] point_x,
  input  logic signed [gps_pkg::COORD_W-1:0] point_y,
  input  gps_pkg::gps_cfg_t                cfg,
  output gps_pkg::gps_prod_t               prod
);
  import gps_pkg::*;

  logic                      s1_valid;
  logic signed [COORD_W-1:0] s1_px, s1_py;
  logic signed [DIFF_W-1:0]  s1_dx, s1_dy;

  logic                      s2_valid;
  logic signed [COORD_W-1:0] s2_px, s2_py;
  logic signed [PROD_W-1:0]  s2_qx, s2_qy;

  logic [INV_W-1:0] inv_x, inv_y;

  // The major axis of a triangular lattice is scaled by the row pitch.
  assign inv_x = (cfg.shape == SHAPE_COLS) ? cfg.inv_row_pitch : cfg.inv_cell_size;
  assign inv_y = (cfg.shape == SHAPE_ROWS) ? cfg.inv_row_pitch : cfg.inv_cell_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_px <= point_x;
    s1_py <= point_y;
    s1_dx <= DIFF_W'(point_x) - DIFF_W'(cfg.origin_x);
    s1_dy <= DIFF_W'(point_y) - DIFF_W'(cfg.origin_y);
    s2_px <= s1_px;
    s2_py <= s1_py;
    s2_qx <= PROD_W'(s1_dx) * PROD_W'($signed({1'b0, inv_x}));
    s2_qy <= PROD_W'(s1_dy) * PROD_W'($signed({1'b0, inv_y}));
  end

  assign prod = '{valid: s2_valid, px: s2_px, py: s2_py, qx: s2_qx, qy: s2_qy};

endmodule

// File: rtl/gps_index.sv
// Index section: rounds the scaled offsets to lattice indices and forms the
// multiplier of each axis' spacing. Depends on gps_pkg; two register stages.
module gps_index (
  input  logic               clk,
  input  logic               rst,
  input  gps_pkg::gps_cfg_t  cfg,
  input  gps_pkg::gps_prod_t prod,
  output gps_pkg::gps_idx_t  idx
);
  import gps_pkg::*;

  localparam logic [PROD_W:0] RND = (PROD_W + 1)'(1) << (SCALE - 1);

  logic [PROD_W:0] sum_x, sum_y;

  logic                      s3_valid;
  logic signed [COORD_W-1:0] s3_px, s3_py;
  logic signed [IDX_W-1:0]   s3_ax, s3_ay;
  logic                      s3_lowx, s3_lowy;

  logic                      s4_valid;
  logic signed [COORD_W-1:0] s4_px, s4_py;
  logic signed [K_W-1:0]     s4_kx, s4_ky;

  logic signed [K_W-1:0]     kx_next, ky_next;

  // Minor index m = a_min - floor(r/2), less one when r is odd and the
  // rounded fraction of the minor axis sits below one half. Returns 2m + r.
  function automatic logic signed [K_W-1:0] minor_k(input logic signed [IDX_W-1:0] a_min,
                                                    input logic signed [IDX_W-1:0] a_maj,
                                                    input logic low);
    logic signed [K_W-1:0] m;
    m = K_W'(a_min) - K_W'(a_maj >>> 1) - K_W'({1'b0, a_maj[0] & low});
    return (m <<< 1) + K_W'(a_maj);
  endfunction

  assign sum_x = (PROD_W + 1)'(prod.qx) + RND;
  assign sum_y = (PROD_W + 1)'(prod.qy) + RND;

  always_comb begin
    case (cfg.shape)
      SHAPE_ROWS: begin
        kx_next = minor_k(s3_ax, s3_ay, s3_lowx);
        ky_next = K_W'(s3_ay);
      end
      SHAPE_COLS: begin
        kx_next = K_W'(s3_ax);
        ky_next = minor_k(s3_ay, s3_ax, s3_lowy);
      end
      default: begin
        kx_next = K_W'(s3_ax);
        ky_next = K_W'(s3_ay);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s3_valid <= prod.valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_px   <= prod.px;
    s3_py   <= prod.py;
    s3_ax   <= $signed(sum_x[PROD_W:SCALE]);
    s3_ay   <= $signed(sum_y[PROD_W:SCALE]);
    s3_lowx <= ~sum_x[SCALE-1];
    s3_lowy <= ~sum_y[SCALE-1];
    s4_px   <= s3_px;
    s4_py   <= s3_py;
    s4_kx   <= kx_next;
    s4_ky   <= ky_next;
  end

  assign idx = '{valid: s4_valid, px: s4_px, py: s4_py, kx: s4_kx, ky: s4_ky};

endmodule

// File: rtl/gps_back.sv
// Back section: scales the lattice multipliers by the spacing, adds the origin,
// clamps to the coordinate range and drives the result. Depends on gps_pkg.
module gps_back (
  input  logic                              clk,
  input  logic                              rst,
  input  gps_pkg::gps_cfg_t                 cfg,
  input  gps_pkg::gps_idx_t                 idx,
  output logic                              done,
  output logic signed [gps_pkg::COORD_W-1:0] snapped_x,
  output logic signed [gps_pkg::COORD_W-1:0] snapped_y,
  output logic                              saturated
);
  import gps_pkg::*;

  logic [SIZE_W-1:0] space_x, space_y;
  logic              minor_x, minor_y, snap;

  logic                      s5_valid;
  logic signed [COORD_W-1:0] s5_px, s5_py;
  logic signed [V_W-1:0]     s5_vx, s5_vy;

  logic [COORD_W:0] fin_x, fin_y;

  // Returns {clamped, coordinate}. A minor axis holds cell_size * (2m + r),
  // which is halved with the half rounded up after adding twice the origin.
  function automatic logic [COORD_W:0] finish(input logic signed [V_W-1:0] v,
                                              input logic signed [COORD_W-1:0] o,
                                              input logic minor);
    logic signed [SUM_W-1:0] tot;
    logic signed [SUM_W-1:0] res;
    logic                    fits;
    tot = SUM_W'(v) + (SUM_W'(o) <<< 1) + SUM_W'(1);
    if (minor) begin
      res = tot >>> 1;
    end else begin
      res = SUM_W'(v) + SUM_W'(o);
    end
    fits = (res[SUM_W-1:COORD_W-1] == '0) || (res[SUM_W-1:COORD_W-1] == '1);
    if (fits) begin
      return {1'b0, res[COORD_W-1:0]};
    end else if (res[SUM_W-1]) begin
      return {1'b1, 1'b1, {(COORD_W - 1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(COORD_W - 1){1'b1}}};
    end
  endfunction

  assign space_x = (cfg.shape == SHAPE_COLS) ? cfg.row_pitch : cfg.cell_size;
  assign space_y = (cfg.shape == SHAPE_ROWS) ? cfg.row_pitch : cfg.cell_size;
  assign minor_x = (cfg.shape == SHAPE_ROWS);
  assign minor_y = (cfg.shape == SHAPE_COLS);
  assign snap    = cfg.enabled && (cfg.shape != SHAPE_UNUSED);

  assign fin_x = finish(s5_vx, cfg.origin_x, minor_x);
  assign fin_y = finish(s5_vy, cfg.origin_y, minor_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s5_valid <= idx.valid;
      done     <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_px <= idx.px;
    s5_py <= idx.py;
    s5_vx <= V_W'(idx.kx) * V_W'($signed({1'b0, space_x}));
    s5_vy <= V_W'(idx.ky) * V_W'($signed({1'b0, space_y}));
    if (snap) begin
      snapped_x <= $signed(fin_x[COORD_W-1:0]);
      snapped_y <= $signed(fin_y[COORD_W-1:0]);
      saturated <= fin_x[COORD_W] | fin_y[COORD_W];
    end else begin
      snapped_x <= s5_px;
      snapped_y <= s5_py;
      saturated <= 1'b0;
    end
  end

endmodule

// File: rtl/grid_point_snap.sv
// Top level of the grid point snap block: configuration registers and the
// six-stage snapping pipeline. Depends on gps_pkg and the gps_* modules.
//
//  channel   handshake                  payload
//  ------    -------------------------  -----------------------------------
//  input     start, busy                point_x, point_y
//  result    done (one-cycle strobe)    snapped_x, snapped_y, saturated
//  config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
// One point is taken per cycle while busy is low; its result passes through
// the six register stages (offset, scale multiply, round, index, spacing
// multiply, origin and clamp). Synchronous reset empties the pipeline; busy
// and a low cfg_ready are shown only during reset. The receiver cannot stall,
// so the pipeline always advances.
module grid_point_snap (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [gps_pkg::COORD_W-1:0] point_x,
  input  logic signed [gps_pkg::COORD_W-1:0] point_y,
  output logic                               done,
  output logic signed [gps_pkg::COORD_W-1:0] snapped_x,
  output logic signed [gps_pkg::COORD_W-1:0] snapped_y,
  output logic                               saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gps_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gps_pkg::*;

  gps_cfg_t  cfg;
  gps_prod_t prod;
  gps_idx_t  idx;
  logic      in_valid;

  assign busy     = rst;
  assign in_valid = start && !busy;

  gps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .point_x  (point_x),
    .point_y  (point_y),
    .cfg      (cfg),
    .prod     (prod)
  );

  gps_index u_index (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .prod (prod),
    .idx  (idx)
  );

  gps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .idx       (idx),
    .done      (done),
    .snapped_x (snapped_x),
    .snapped_y (snapped_y),
    .saturated (saturated)
  );

endmodule

// File: rtl/gps_checker.sv
// Port-level checker for grid_point_snap, attached to the top level by bind.
// Depends on gps_pkg and grid_point_snap_macros.svh.
`include "grid_point_snap_macros.svh"

module gps_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic signed [gps_pkg::COORD_W-1:0] snapped_x,
  input logic signed [gps_pkg::COORD_W-1:0] snapped_y,
  input logic                               saturated
);
  import gps_pkg::*;

  localparam logic signed [COORD_W-1:0] MAX_C = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic signed [COORD_W-1:0] MIN_C = {1'b1, {(COORD_W - 1){1'b0}}};

  logic at_end;

  assign at_end = (snapped_x == MAX_C) || (snapped_x == MIN_C) ||
                  (snapped_y == MAX_C) || (snapped_y == MIN_C);

  // Every transfer yields its result on done once it leaves the pipeline.
  `GPS_ASSERT_DLY(a_latency, start && !busy, PIPE_DEPTH, done)

  // No result appears without a transfer at the matching earlier edge.
  `GPS_ASSERT_IMP(a_no_orphan, done, $past(start && !busy, PIPE_DEPTH))

  // A clamped result has at least one coordinate at an end of the range.
  `GPS_ASSERT_IMP(a_sat_clamped, done && saturated, at_end)

endmodule

bind grid_point_snap gps_checker u_gps_checker (.*);
